// ===== design/rrpe_pkg.sv =====
package rrpe_pkg;

   localparam int RECORD_BYTES_DEF = 16;
   localparam int HEADER_LEN = 7;

   localparam logic [15:0] LIMIT_RESET = 16'd1023;
   localparam logic [7:0] ACK_BYTE = 8'h06;
   localparam logic [7:0] NAK_BYTE = 8'h15;
   localparam logic [7:0] CMD_LEAD = 8'h29;
   localparam logic [7:0] ECHO_LEAD = 8'h28;
   localparam logic [7:0] CHAR_FOUR = 8'h34;
   localparam logic [3:0] DIGIT_HIGH = 4'h3;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_RX = 2'd1,
      OP_TIMEOUT = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_TX = 2'd0,
      KIND_REC = 2'd1,
      KIND_STAT = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_BARE_NAK = 3'd1,
      ST_HDR_NAK = 3'd2,
      ST_RANGE = 3'd3,
      ST_TRUNC = 3'd4,
      ST_BAD_HDR = 3'd5,
      ST_BAD_NIB = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_HEADER = 3'b010,
      PH_PAYLOAD = 3'b100
   } phase_type;

   typedef struct packed {
      logic accept;
      logic emit_tx;
      logic emit_rec;
      logic emit_stat;
   } ctl_cmd_type;

   typedef struct packed {
      logic start_tx;
      logic start_rec;
      logic start_stat;
      logic tx_end;
      logic rec_end;
      logic out_free;
   } dp_status_type;

   // character i of a header: lead, '4', '0', then four address digits
   function automatic logic [7:0] header_char(input logic [7:0] lead, input logic [2:0] i,
                                              input logic [15:0] a);
      logic [7:0] c;
      case (i)
         3'd0: c = lead;
         3'd1: c = CHAR_FOUR;
         3'd2: c = {DIGIT_HIGH, 4'h0};
         3'd3: c = {DIGIT_HIGH, a[15:12]};
         3'd4: c = {DIGIT_HIGH, a[11:8]};
         3'd5: c = {DIGIT_HIGH, a[7:4]};
         default: c = {DIGIT_HIGH, a[3:0]};
      endcase
      return c;
   endfunction

endpackage

// ===== design/rrpe_if.sv =====
interface rrpe_req_if import rrpe_pkg::*; ();
   logic valid;
   logic ready;
   logic [1:0] op;
   logic [15:0] addr;
   logic chain;
   logic [7:0] rx_byte;

   modport source (output valid, op, addr, chain, rx_byte, input ready);
   modport sink (input valid, op, addr, chain, rx_byte, output ready);
endinterface

interface rrpe_rsp_if import rrpe_pkg::*; ();
   logic valid;
   logic ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic [2:0] status;
   logic last;

   modport source (output valid, kind, out_byte, status, last, input ready);
   modport sink (input valid, kind, out_byte, status, last, output ready);
endinterface

// ===== design/rrpe_ctrl.sv =====
module rrpe_ctrl import rrpe_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input dp_status_type sts,
   output ctl_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_TX = 5'b00010,
      S_PREP = 5'b00100,
      S_REC = 5'b01000,
      S_STAT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) begin
               if (sts.start_tx) begin
                  state_in = S_TX;
               end else if (sts.start_rec) begin
                  state_in = S_PREP;
               end else if (sts.start_stat) begin
                  state_in = S_STAT;
               end
            end
         end
         S_TX: begin
            cmd.emit_tx = sts.out_free;
            if (sts.out_free && sts.tx_end) begin
               state_in = S_IDLE;
            end
         end
         S_PREP: begin
            state_in = S_REC;
         end
         S_REC: begin
            cmd.emit_rec = sts.out_free;
            if (sts.out_free && sts.rec_end) begin
               state_in = S_STAT;
            end
         end
         S_STAT: begin
            cmd.emit_stat = sts.out_free;
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/rrpe_datapath.sv =====
module rrpe_datapath import rrpe_pkg::*; #(
   parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
   input logic clock,
   input logic reset,
   input logic csr_wr_en,
   input logic [15:0] csr_wr_data,
   input logic [1:0] req_op,
   input logic [15:0] req_addr,
   input logic req_chain,
   input logic [7:0] req_rx_byte,
   input logic rsp_ready,
   output logic rsp_valid,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_status,
   output logic rsp_last,
   input ctl_cmd_type cmd,
   output dp_status_type sts
);

   localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
   localparam int CNT_MIN = $clog2(2 * RECORD_BYTES + 1);
   localparam int CNT_W = (CNT_MIN > 3) ? CNT_MIN : 3;
   localparam logic [CNT_W-1:0] HDR_END = CNT_W'(HEADER_LEN);
   localparam logic [CNT_W-1:0] PAY_END = CNT_W'(2 * RECORD_BYTES);
   localparam logic [IDX_W-1:0] REC_LAST = IDX_W'(RECORD_BYTES - 1);

   logic [7:0] mem [RECORD_BYTES];

   phase_type phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_inc;
   logic pend_ff, pend_in;
   logic [15:0] exp_ff, exp_in;
   logic hb_ff, hb_in;
   logic nb_ff, nb_in;
   logic [3:0] hn_ff, hn_in;
   logic chain_ff, chain_in;
   status_type stat_ff, stat_in;
   logic [2:0] tx_idx_ff, tx_idx_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [7:0] rd_data_ff;
   logic [15:0] limit_ff;

   logic out_valid_ff;
   logic [1:0] out_kind_ff;
   logic [7:0] out_byte_ff;
   logic [2:0] out_status_ff;
   logic out_last_ff;

   logic wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [7:0] wr_data;
   logic [16:0] top_addr;
   logic [7:0] tx_byte;

   assign cnt_inc = cnt_ff + 1'b1;
   assign top_addr = {1'b0, req_addr} + 17'(RECORD_BYTES - 1);
   assign wr_idx = cnt_ff[IDX_W:1];
   assign wr_data = {hn_ff, req_rx_byte[3:0]};
   assign tx_byte = (tx_idx_ff == 3'd0) ? ACK_BYTE :
                    header_char(CMD_LEAD, tx_idx_ff - 3'd1, exp_ff);

   always_comb begin
      phase_in = phase_ff;
      cnt_in = cnt_ff;
      pend_in = pend_ff;
      exp_in = exp_ff;
      hb_in = hb_ff;
      nb_in = nb_ff;
      hn_in = hn_ff;
      chain_in = chain_ff;
      stat_in = stat_ff;
      tx_idx_in = tx_idx_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_en = 1'b0;
      sts.start_tx = 1'b0;
      sts.start_rec = 1'b0;
      sts.start_stat = 1'b0;
      sts.tx_end = (tx_idx_ff == 3'(HEADER_LEN));
      sts.rec_end = (rd_ptr_ff == REC_LAST);
      sts.out_free = !out_valid_ff || rsp_ready;

      if (cmd.accept) begin
         case (req_op)
            OP_START: begin
               if (top_addr > {1'b0, limit_ff}) begin
                  stat_in = ST_RANGE;
                  sts.start_stat = 1'b1;
               end else begin
                  tx_idx_in = pend_ff ? 3'd0 : 3'd1;
                  pend_in = 1'b0;
                  exp_in = req_addr;
                  chain_in = req_chain;
                  cnt_in = '0;
                  hb_in = 1'b0;
                  nb_in = 1'b0;
                  hn_in = 4'h0;
                  phase_in = PH_HEADER;
                  sts.start_tx = 1'b1;
               end
            end
            OP_RX: begin
               if (phase_ff == PH_HEADER) begin
                  if (cnt_ff == '0 && req_rx_byte == NAK_BYTE) begin
                     stat_in = ST_BARE_NAK;
                     phase_in = PH_IDLE;
                     sts.start_stat = 1'b1;
                  end else begin
                     hb_in = hb_ff || (req_rx_byte != header_char(ECHO_LEAD, cnt_ff[2:0],
                                                                  exp_ff));
                     cnt_in = cnt_inc;
                     if (cnt_inc == HDR_END) begin
                        if (hb_in) begin
                           stat_in = ST_BAD_HDR;
                           phase_in = PH_IDLE;
                           sts.start_stat = 1'b1;
                        end else begin
                           phase_in = PH_PAYLOAD;
                           cnt_in = '0;
                        end
                     end
                  end
               end else if (phase_ff == PH_PAYLOAD) begin
                  if (cnt_ff == '0 && req_rx_byte == NAK_BYTE) begin
                     stat_in = ST_HDR_NAK;
                     phase_in = PH_IDLE;
                     sts.start_stat = 1'b1;
                  end else begin
                     nb_in = nb_ff || (req_rx_byte[7:4] != DIGIT_HIGH);
                     if (!cnt_ff[0]) begin
                        hn_in = req_rx_byte[3:0];
                     end else begin
                        wr_en = 1'b1;
                     end
                     cnt_in = cnt_inc;
                     if (cnt_inc == PAY_END) begin
                        phase_in = PH_IDLE;
                        if (nb_in) begin
                           stat_in = ST_BAD_NIB;
                           sts.start_stat = 1'b1;
                        end else begin
                           stat_in = ST_OK;
                           pend_in = pend_ff || chain_ff;
                           rd_ptr_in = '0;
                           sts.start_rec = 1'b1;
                        end
                     end
                  end
               end
            end
            OP_TIMEOUT: begin
               if (phase_ff != PH_IDLE) begin
                  stat_in = ST_TRUNC;
                  phase_in = PH_IDLE;
                  sts.start_stat = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.emit_tx) begin
         tx_idx_in = tx_idx_ff + 3'd1;
      end
      if (cmd.emit_rec) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[rd_ptr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff <= '0;
         pend_ff <= 1'b0;
         exp_ff <= '0;
         hb_ff <= 1'b0;
         nb_ff <= 1'b0;
         hn_ff <= 4'h0;
         chain_ff <= 1'b0;
         stat_ff <= ST_OK;
         tx_idx_ff <= 3'd0;
         rd_ptr_ff <= '0;
         limit_ff <= LIMIT_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff <= cnt_in;
         pend_ff <= pend_in;
         exp_ff <= exp_in;
         hb_ff <= hb_in;
         nb_ff <= nb_in;
         hn_ff <= hn_in;
         chain_ff <= chain_in;
         stat_ff <= stat_in;
         tx_idx_ff <= tx_idx_in;
         rd_ptr_ff <= rd_ptr_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (cmd.emit_tx || cmd.emit_rec || cmd.emit_stat) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_tx) begin
         out_kind_ff <= KIND_TX;
         out_byte_ff <= tx_byte;
         out_status_ff <= ST_OK;
         out_last_ff <= sts.tx_end;
      end else if (cmd.emit_rec) begin
         out_kind_ff <= KIND_REC;
         out_byte_ff <= rd_data_ff;
         out_status_ff <= ST_OK;
         out_last_ff <= 1'b0;
      end else if (cmd.emit_stat) begin
         out_kind_ff <= KIND_STAT;
         out_byte_ff <= 8'h00;
         out_status_ff <= stat_ff;
         out_last_ff <= 1'b1;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_kind = out_kind_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_status = out_status_ff;
   assign rsp_last = out_last_ff;

endmodule

// ===== design/record_read_protocol_engine.sv =====
// Host-side engine for one record read over a nibble-coded serial link.
// req: one transaction per event: start (address, chain flag), received byte
//   or receive timeout. csr_wr_en/csr_wr_data set the address limit
//   (reset 1023).
// rsp: transmit bytes, decoded record bytes and a final status; last marks
//   the final transaction caused by a request.
// A start within range gives 7 transmit bytes (8 with an owed ACK), one per
//   cycle while the receiver does not stall.
// The payload byte that completes the record gives a first record store read in
//   a preparation state, then RECORD_BYTES record bytes and a status, one per
//   cycle while the receiver does not stall. Every other result is a single status.
// Requests causing no result leave req.ready high; otherwise req.ready stays low
//   until the last result has been loaded into the output register.
// A stalled receiver holds the output register and the engine waits.
// Reset returns to idle with no ACK owed; the record store is not cleared.
module record_read_protocol_engine import rrpe_pkg::*; #(
   parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
   input logic clock,
   input logic reset,
   input logic csr_wr_en,
   input logic [15:0] csr_wr_data,
   rrpe_req_if.sink req,
   rrpe_rsp_if.source rsp
);

   ctl_cmd_type cmd;
   dp_status_type sts;

   rrpe_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req.valid),
      .req_ready(req.ready),
      .sts(sts),
      .cmd(cmd)
   );

   rrpe_datapath #(
      .RECORD_BYTES(RECORD_BYTES)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_op(req.op),
      .req_addr(req.addr),
      .req_chain(req.chain),
      .req_rx_byte(req.rx_byte),
      .rsp_ready(rsp.ready),
      .rsp_valid(rsp.valid),
      .rsp_kind(rsp.kind),
      .rsp_out_byte(rsp.out_byte),
      .rsp_status(rsp.status),
      .rsp_last(rsp.last),
      .cmd(cmd),
      .sts(sts)
   );

endmodule
